// ===== sv/lcsl_pkg.sv =====
// Package for the longest common substring length block.
// Holds the item payload types, the operation codes, the controller states and
// the per-cell control struct. No dependencies.
package lcsl_pkg;

    localparam int SYMBOL_W  = 8;
    localparam int LONGEST_W = 7;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_TEXT = 1'b1
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [SYMBOL_W-1:0] symbol;
        logic                last;
    } t_in_item;

    typedef struct packed {
        logic [LONGEST_W-1:0] longest;
        logic                 pattern_clipped;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DRAIN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic shift;
        logic fresh;
        logic step;
        logic drain;
        logic clear;
    } t_cell_ctl;

endpackage

// ===== sv/lcsl_cell.sv =====
// One cell of the match chain: a pattern symbol, its valid bit, its match
// count and its running best. Depends on lcsl_pkg.
module lcsl_cell
    import lcsl_pkg::*;
#(
    parameter int SYMBOL_BITS = 8,
    parameter int LW          = 7
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cell_ctl              i_ctl,
    input  logic [SYMBOL_BITS-1:0] i_text,
    input  logic [SYMBOL_BITS-1:0] i_sym_in,
    input  logic                   i_vld_in,
    input  logic [LW-1:0]          i_diag,
    input  logic [LW-1:0]          i_best_in,
    output logic [SYMBOL_BITS-1:0] o_sym,
    output logic                   o_vld,
    output logic [LW-1:0]          o_match,
    output logic [LW-1:0]          o_best
);

    logic [SYMBOL_BITS-1:0] r_sym;
    logic                   r_vld;
    logic [LW-1:0]          r_match;
    logic [LW-1:0]          r_best;
    logic [LW-1:0]          n_match;
    logic [LW-1:0]          n_best;
    logic                   n_vld;

    always_comb begin
        n_vld   = r_vld;
        n_match = r_match;
        n_best  = r_best;
        if (i_ctl.shift) begin
            n_vld = i_vld_in;
        end
        if (i_ctl.fresh || i_ctl.clear) begin
            n_match = '0;
            n_best  = '0;
        end else if (i_ctl.step) begin
            n_match = (r_vld && (r_sym == i_text)) ? i_diag + LW'(1) : '0;
            if (n_match > r_best) begin
                n_best = n_match;
            end
        end else if (i_ctl.drain) begin
            if (i_best_in > r_best) begin
                n_best = i_best_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= 1'b0;
            r_match <= '0;
            r_best  <= '0;
        end else begin
            r_vld   <= n_vld;
            r_match <= n_match;
            r_best  <= n_best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_sym <= i_sym_in;
        end
    end

    assign o_sym   = r_sym;
    assign o_vld   = r_vld;
    assign o_match = r_match;
    assign o_best  = r_best;

endmodule

// ===== sv/longest_common_substring_length.sv =====
// Longest common substring length over a chain of MAX_LEN cells.
// A pattern item or a non-final text item is taken in ST_RUN; for a final text item the
// running best ripples down the chain in ST_DRAIN, then ST_OUT loads the output
// register once it is free. Throughput: one item per cycle in ST_RUN; after a final text
// item no new item is taken until its result is loaded into the output register.
// Reset (synchronous, active low) empties the pattern, clears all counts and the clip and output-valid flags.
module longest_common_substring_length
    import lcsl_pkg::*;
#(
    parameter int MAX_LEN     = 64,
    parameter int SYMBOL_BITS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int LW        = $clog2(MAX_LEN + 1);
    localparam int CW        = $clog2((MAX_LEN > 1) ? MAX_LEN : 2);
    localparam int DRAIN_N   = (MAX_LEN > 1) ? (MAX_LEN - 2) : 0;
    localparam bit HAS_DRAIN = (MAX_LEN > 1);

    logic [SYMBOL_BITS-1:0] w_sym   [MAX_LEN];
    logic                   w_vld   [MAX_LEN];
    logic [LW-1:0]          w_match [MAX_LEN];
    logic [LW-1:0]          w_best  [MAX_LEN];

    t_state    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic      r_complete, n_complete;
    logic      r_clip, n_clip;
    logic      r_out_vld, n_out_vld;
    t_out_item r_out, n_out;
    logic      n_out_load;
    t_cell_ctl w_ctl;
    logic      w_acc;

    logic [SYMBOL_BITS+SYMBOL_W-1:0] w_sym_ext;
    logic [SYMBOL_BITS-1:0]          w_in_sym;
    logic [LW+LONGEST_W-1:0]         w_best_ext;

    assign w_sym_ext  = {{SYMBOL_BITS{1'b0}}, i_in_item.symbol};
    assign w_in_sym   = w_sym_ext[SYMBOL_BITS-1:0];
    assign w_best_ext = {{LONGEST_W{1'b0}}, w_best[0]};

    assign o_in_ready = (r_state == ST_RUN);
    assign w_acc      = i_in_valid && o_in_ready;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_complete = r_complete;
        n_clip     = r_clip;
        n_out_vld  = r_out_vld && !i_out_ready;
        n_out      = r_out;
        n_out_load = 1'b0;
        w_ctl      = '0;
        unique case (r_state)
            ST_RUN: begin
                if (w_acc) begin
                    if (i_in_item.op == OP_LOAD) begin
                        w_ctl.fresh = r_complete;
                        if (!r_complete && w_vld[MAX_LEN-1]) begin
                            n_clip = 1'b1;
                        end else begin
                            w_ctl.shift = 1'b1;
                        end
                        if (r_complete) begin
                            n_clip = 1'b0;
                        end
                        n_complete = i_in_item.last;
                    end else begin
                        w_ctl.step = 1'b1;
                        n_complete = 1'b1;
                        if (i_in_item.last) begin
                            n_cnt   = '0;
                            n_state = HAS_DRAIN ? ST_DRAIN : ST_OUT;
                        end
                    end
                end
            end
            ST_DRAIN: begin
                w_ctl.drain = 1'b1;
                n_cnt       = r_cnt + CW'(1);
                if (r_cnt == CW'(DRAIN_N)) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_vld || i_out_ready) begin
                    n_out_load            = 1'b1;
                    n_out_vld             = 1'b1;
                    n_out.longest         = w_best_ext[LONGEST_W-1:0];
                    n_out.pattern_clipped = r_clip;
                    w_ctl.clear           = 1'b1;
                    n_state               = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_RUN;
            r_cnt      <= '0;
            r_complete <= 1'b1;
            r_clip     <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_complete <= n_complete;
            r_clip     <= n_clip;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
        logic [SYMBOL_BITS-1:0] w_sym_in;
        logic                   w_vld_in;
        logic [LW-1:0]          w_diag;
        logic [LW-1:0]          w_best_in;

        if (k == 0) begin : g_head
            assign w_sym_in = w_in_sym;
            assign w_vld_in = 1'b1;
        end else begin : g_body
            assign w_sym_in = w_sym[k-1];
            assign w_vld_in = w_vld[k-1] && !w_ctl.fresh;
        end

        if (k == MAX_LEN - 1) begin : g_tail
            assign w_diag    = '0;
            assign w_best_in = '0;
        end else begin : g_link
            assign w_diag    = w_match[k+1];
            assign w_best_in = w_best[k+1];
        end

        lcsl_cell #(
            .SYMBOL_BITS (SYMBOL_BITS),
            .LW          (LW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_text    (w_in_sym),
            .i_sym_in  (w_sym_in),
            .i_vld_in  (w_vld_in),
            .i_diag    (w_diag),
            .i_best_in (w_best_in),
            .o_sym     (w_sym[k]),
            .o_vld     (w_vld[k]),
            .o_match   (w_match[k]),
            .o_best    (w_best[k])
        );
    end

endmodule

// ===== sim/tb.sv =====
// Testbench for longest_common_substring_length: streams pattern and text items, predicts
// each reported length with a bench-side copy of the row update, and checks every result.
// Depends on lcsl_pkg and the longest_common_substring_length RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lcsl_pkg::*;

    localparam int CELLS = 64;
    localparam int ITEMS = 1400;
    localparam int LIMIT = 1000000;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    longest_common_substring_length #(
        .MAX_LEN(CELLS),
        .SYMBOL_BITS(SYMBOL_W)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(in_valid),
        .o_in_ready(in_ready),
        .i_in_item(in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item(out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // bench-side copy of the block state
    logic [SYMBOL_W-1:0]  pattern_bytes [CELLS];
    logic [LONGEST_W-1:0] match_cells [CELLS] = '{default: '0};
    logic [LONGEST_W-1:0] best_run = '0;
    int                   pattern_len = 0;
    logic                 pattern_done = 1'b1;
    logic                 pattern_clip = 1'b0;

    t_out_item      expected_results [$];
    t_in_item       pending_items [$];
    int             sent_items = 0;
    int             cycles = 0;
    int             errors = 0;
    bit             quiet = 1'b0;
    bit             took = 1'b0;

    function automatic void clear_row();
        foreach (match_cells[k]) match_cells[k] = '0;
        best_run = '0;
    endfunction

    function automatic void predict_row_update(t_in_item it);
        logic [LONGEST_W-1:0] diag;
        if (it.op == OP_LOAD) begin
            if (pattern_done) begin
                pattern_len = 0;
                pattern_clip = 1'b0;
                pattern_done = 1'b0;
                clear_row();
            end
            if (pattern_len < CELLS) begin
                pattern_bytes[pattern_len] = it.symbol;
                pattern_len++;
            end else begin
                pattern_clip = 1'b1;
            end
            if (it.last) pattern_done = 1'b1;
        end else begin
            pattern_done = 1'b1;
            // walk downward so each cell still sees the old diagonal
            for (int j = pattern_len - 1; j >= 0; j--) begin
                if (pattern_bytes[j] == it.symbol) begin
                    diag = (j > 0) ? match_cells[j-1] : '0;
                    match_cells[j] = diag + 1'b1;
                    if (match_cells[j] > best_run) best_run = match_cells[j];
                end else begin
                    match_cells[j] = '0;
                end
            end
            if (it.last) begin
                expected_results.push_back(t_out_item'{longest: best_run,
                                                       pattern_clipped: pattern_clip});
                clear_row();
            end
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // accept input items
    always @(posedge i_clk) begin
        took = i_rst_n && in_valid && in_ready;
        if (took) begin
            predict_row_update(in_item);
        end
    end

    // drive input items
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !took) begin
            // hold
        end else if (pending_items.size() != 0 && (quiet || $urandom_range(99) >= 19)) begin
            in_item  <= pending_items.pop_front();
            in_valid <= 1'b1;
        end else begin
            in_valid <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 19);
    end

    // check results
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with none expected, longest", out_item.longest, -1);
            end else begin
                want = expected_results.pop_front();
                if (out_item.longest !== want.longest)
                    report_mismatch("longest", out_item.longest, want.longest);
                if (out_item.pattern_clipped !== want.pattern_clipped)
                    report_mismatch("pattern_clipped", out_item.pattern_clipped,
                                    want.pattern_clipped);
            end
        end
    end

    task automatic send_item(t_op op, logic [SYMBOL_W-1:0] sym, logic fin);
        t_in_item it;
        it.op     = op;
        it.symbol = sym;
        it.last   = fin;
        while (pending_items.size() >= 2) @(posedge i_clk);
        pending_items.push_back(it);
        sent_items++;
    endtask

    task automatic await_results();
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_empty_pattern();
        send_item(OP_TEXT, 8'h00, 1'b0);
        send_item(OP_TEXT, 8'hFF, 1'b1);
    endtask

    task automatic test_match_extremes();
        send_item(OP_LOAD, 8'h00, 1'b0);
        send_item(OP_LOAD, 8'hFF, 1'b0);
        send_item(OP_LOAD, 8'h00, 1'b0);
        send_item(OP_LOAD, 8'h7F, 1'b1);
        send_item(OP_TEXT, 8'hFF, 1'b0);
        send_item(OP_TEXT, 8'h00, 1'b0);
        send_item(OP_TEXT, 8'h7F, 1'b0);
        send_item(OP_TEXT, 8'hFF, 1'b1);
        send_item(OP_TEXT, 8'h7F, 1'b1);
    endtask

    task automatic test_open_load();
        await_results();
        send_item(OP_LOAD, 8'h11, 1'b0);
        send_item(OP_LOAD, 8'h22, 1'b0);
        send_item(OP_TEXT, 8'h22, 1'b1);
        send_item(OP_TEXT, 8'h11, 1'b0);
        send_item(OP_LOAD, 8'h33, 1'b1);
        send_item(OP_TEXT, 8'h33, 1'b1);
        send_item(OP_LOAD, 8'h44, 1'b0);
        send_item(OP_LOAD, 8'h55, 1'b1);
        send_item(OP_LOAD, 8'h66, 1'b1);
        send_item(OP_TEXT, 8'h66, 1'b1);
        send_item(OP_LOAD, 8'hAA, 1'b0);
        send_item(OP_LOAD, 8'h55, 1'b0);
        send_item(OP_TEXT, 8'hAA, 1'b0);
        send_item(OP_TEXT, 8'h55, 1'b1);
    endtask

    task automatic test_full_capacity();
        logic [SYMBOL_W-1:0] pat [$];
        for (int pass = 0; pass < 2; pass++) begin
            pat.delete();
            for (int i = 0; i < CELLS + (pass == 0 ? 6 : 0); i++) begin
                pat.push_back(SYMBOL_W'($urandom_range(255)));
                send_item(OP_LOAD, pat[i], i == CELLS + (pass == 0 ? 5 : -1));
            end
            for (int i = 0; i < CELLS; i++)
                send_item(OP_TEXT, pat[i], i == CELLS - 1);
        end
    endtask

    task automatic test_random_streams();
        logic [SYMBOL_W-1:0] pat [$];
        logic [SYMBOL_W-1:0] alpha [3];
        logic [SYMBOL_W-1:0] sym;
        int plen;
        int tlen;
        int kind;
        int start;
        quiet = 1'b1;
        while (sent_items < ITEMS) begin
            if (sent_items > 650) quiet = 1'b0;
            kind = $urandom_range(99);
            foreach (alpha[k]) alpha[k] = SYMBOL_W'($urandom_range(255));
            plen = ($urandom_range(24) == 0) ? $urandom_range(CELLS - 4, CELLS + 8)
                                             : $urandom_range(1, 12);
            pat.delete();
            for (int i = 0; i < plen; i++) begin
                pat.push_back(alpha[$urandom_range(2)]);
                send_item(OP_LOAD, pat[i], i == plen - 1 && kind >= 10);
            end
            repeat ((kind >= 80) ? $urandom_range(2, 3) : 1) begin
                tlen = (plen > 12 && $urandom_range(1)) ? $urandom_range(plen - 8, plen + 4)
                                                        : $urandom_range(1, 12);
                start = $urandom_range(plen - 1);
                for (int i = 0; i < tlen; i++) begin
                    sym = $urandom_range(2) ? pat[(start + i) % plen] : alpha[$urandom_range(2)];
                    send_item(OP_TEXT, sym, i == tlen - 1 && !(kind >= 10 && kind < 15));
                end
            end
            if (kind >= 15 && kind < 25) begin
                repeat ($urandom_range(1, 4))
                    send_item(t_op'(1'($urandom_range(1))), SYMBOL_W'($urandom_range(255)),
                              1'($urandom_range(1)));
            end
        end
        quiet = 1'b0;
    endtask

    initial begin
        i_rst_n   = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_pattern();
        test_match_extremes();
        test_open_load();
        test_full_capacity();
        test_random_streams();

        await_results();
        repeat (CELLS + 8) @(posedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
